/* sv/accel_tilt_roll_pitch_macros.svh */
// assertion macros used by the checker
`ifndef ACCEL_TILT_ROLL_PITCH_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_MACROS_SVH

// same-cycle implication, off during reset
`define ATRP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atrp check failed");

// next-cycle implication, off during reset
`define ATRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atrp check failed");

// next-cycle implication, also checked in reset
`define ATRP_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("atrp check failed");

`endif

/* sv/atrp_pkg.sv */
`timescale 1ns / 1ps
package atrp_pkg;

  localparam int SAMPLE_BITS      = 14;
  localparam int ANGLE_ITERATIONS = 16;

  localparam int RAD_W   = 2 * SAMPLE_BITS + 16;
  localparam int ROOT_W  = SAMPLE_BITS + 8;
  localparam int REM_W   = ROOT_W + 2;
  localparam int OPIN_W  = ROOT_W + 1;
  localparam int OP_SHIFT = 24;
  localparam int OP_W    = OPIN_W + OP_SHIFT + 3;
  localparam int ACC_W   = 32;
  localparam int ANG_W   = 17;
  localparam int FRAC_W  = 16;

  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;

  localparam int IN_W  = 3 * SAMPLE_BITS;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = 31;
  localparam int OUT_TW = 32;

  typedef struct packed {
    logic                    fixed_en;
    logic signed [ANG_W-1:0] fixed_val;
    logic signed [ANG_W-1:0] base;
  } angle_ctl_t;

  typedef struct packed {
    angle_ctl_t             ctl;
    logic signed [OP_W-1:0] xv;
    logic signed [OP_W-1:0] yv;
  } cordic_init_t;

  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd294912000;
      5'd1:  v = 32'sd174096719;
      5'd2:  v = 32'sd91987925;
      5'd3:  v = 32'sd46694507;
      5'd4:  v = 32'sd23437865;
      5'd5:  v = 32'sd11730358;
      5'd6:  v = 32'sd5866610;
      5'd7:  v = 32'sd2933484;
      5'd8:  v = 32'sd1466764;
      5'd9:  v = 32'sd733385;
      5'd10: v = 32'sd366693;
      5'd11: v = 32'sd183346;
      5'd12: v = 32'sd91673;
      5'd13: v = 32'sd45837;
      5'd14: v = 32'sd22918;
      5'd15: v = 32'sd11459;
      5'd16: v = 32'sd5730;
      5'd17: v = 32'sd2865;
      5'd18: v = 32'sd1432;
      5'd19: v = 32'sd716;
      5'd20: v = 32'sd358;
      5'd21: v = 32'sd179;
      5'd22: v = 32'sd90;
      5'd23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  // special cases and quadrant fold ahead of the rotation stages
  function automatic cordic_init_t cordic_prep(input logic signed [OPIN_W-1:0] num,
                                               input logic signed [OPIN_W-1:0] den);
    cordic_init_t            r;
    logic signed [OP_W-1:0]  n_ext;
    logic signed [OP_W-1:0]  d_ext;
    n_ext = OP_W'(num);
    d_ext = OP_W'(den);
    r.ctl.fixed_en  = 1'b0;
    r.ctl.fixed_val = '0;
    r.ctl.base      = '0;
    if (num == '0) begin
      r.ctl.fixed_en  = 1'b1;
      r.ctl.fixed_val = (den < 0) ? ANG_W'(HALF_TURN) : '0;
    end else if (den == '0) begin
      r.ctl.fixed_en  = 1'b1;
      r.ctl.fixed_val = (num > 0) ? ANG_W'(QUARTER_TURN) : -ANG_W'(QUARTER_TURN);
    end else if (den < 0) begin
      r.ctl.base = (num > 0) ? ANG_W'(HALF_TURN) : -ANG_W'(HALF_TURN);
      n_ext = -n_ext;
      d_ext = -d_ext;
    end
    r.xv = d_ext <<< OP_SHIFT;
    r.yv = n_ext <<< OP_SHIFT;
    return r;
  endfunction

endpackage

/* sv/accel_tilt_roll_pitch.sv */
`timescale 1ns / 1ps
// pipeline: 22 square-root stages, one fold stage, 16 rotation stages,
// one rounding and output stage
// throughput: one item per cycle; all stages advance together and hold while
// the output register waits on out_tready
// reset: rst_n synchronous, active low, clears every stage valid bit
module accel_tilt_roll_pitch
  import atrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // accel_x, accel_y, accel_z, zero pad
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata   // roll_angle, pitch_angle, zero pad
);

  localparam int IT = ANGLE_ITERATIONS;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // square root of (y*y + z*z) << 16, one result bit per stage
  logic                   sv_r   [ROOT_W];
  logic [IN_W-1:0]        sxyz_r [ROOT_W];
  logic [RAD_W-1:0]       srad_r [ROOT_W];
  logic [REM_W-1:0]       srem_r [ROOT_W];
  logic [ROOT_W-1:0]      sroot_r[ROOT_W];

  logic signed [SAMPLE_BITS-1:0]   in_y;
  logic signed [SAMPLE_BITS-1:0]   in_z;
  logic signed [2*SAMPLE_BITS-1:0] sq_y;
  logic signed [2*SAMPLE_BITS-1:0] sq_z;
  logic [2*SAMPLE_BITS-1:0]        sq_sum;

  assign in_y   = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_z   = in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign sq_y   = in_y * in_y;
  assign sq_z   = in_z * in_z;
  assign sq_sum = $unsigned(sq_y) + $unsigned(sq_z);

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic              p_v;
    logic [IN_W-1:0]   p_xyz;
    logic [RAD_W-1:0]  p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  trial;
    if (k == 0) begin : g_first
      assign p_v    = in_tvalid;
      assign p_xyz  = in_tdata[IN_W-1:0];
      assign p_rad  = {sq_sum, 16'b0};
      assign p_rem  = '0;
      assign p_root = '0;
    end else begin : g_next
      assign p_v    = sv_r[k-1];
      assign p_xyz  = sxyz_r[k-1];
      assign p_rad  = srad_r[k-1];
      assign p_rem  = srem_r[k-1];
      assign p_root = sroot_r[k-1];
    end
    assign rem_in = {p_rem[REM_W-3:0], p_rad[RAD_W-1:RAD_W-2]};
    assign trial  = {p_root, 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (adv) begin
        sv_r[k] <= p_v;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sxyz_r[k] <= p_xyz;
        srad_r[k] <= {p_rad[RAD_W-3:0], 2'b00};
        if (rem_in >= trial) begin
          srem_r[k]  <= rem_in - trial;
          sroot_r[k] <= {p_root[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r[k]  <= rem_in;
          sroot_r[k] <= {p_root[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // fold stage: lane 0 is roll, lane 1 is pitch
  logic signed [SAMPLE_BITS-1:0] f_x;
  logic signed [SAMPLE_BITS-1:0] f_y;
  logic signed [SAMPLE_BITS-1:0] f_z;
  cordic_init_t init_roll;
  cordic_init_t init_pitch;

  assign f_x = sxyz_r[ROOT_W-1][SAMPLE_BITS-1:0];
  assign f_y = sxyz_r[ROOT_W-1][2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign f_z = sxyz_r[ROOT_W-1][3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign init_roll  = cordic_prep(OPIN_W'(f_y), OPIN_W'(f_z));
  assign init_pitch = cordic_prep(OPIN_W'(f_x) <<< 8,
                                  $signed({1'b0, sroot_r[ROOT_W-1]}));

  logic                    pv_r;
  angle_ctl_t              pctl_r[2];
  logic signed [OP_W-1:0]  px_r  [2];
  logic signed [OP_W-1:0]  py_r  [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= sv_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pctl_r[0] <= init_roll.ctl;
      px_r[0]   <= init_roll.xv;
      py_r[0]   <= init_roll.yv;
      pctl_r[1] <= init_pitch.ctl;
      px_r[1]   <= init_pitch.xv;
      py_r[1]   <= init_pitch.yv;
    end
  end

  // rotation stages
  logic                    cv_r  [IT];
  angle_ctl_t              cctl_r[IT][2];
  logic signed [OP_W-1:0]  cx_r  [IT][2];
  logic signed [OP_W-1:0]  cy_r  [IT][2];
  logic signed [ACC_W-1:0] cacc_r[IT][2];

  for (genvar i = 0; i < IT; i++) begin : g_rot
    logic                    p_v;
    always_comb begin
      if (i == 0) p_v = pv_r;
      else        p_v = cv_r[(i == 0) ? 0 : i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else if (adv) begin
        cv_r[i] <= p_v;
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      angle_ctl_t              p_ctl;
      logic signed [OP_W-1:0]  p_x;
      logic signed [OP_W-1:0]  p_y;
      logic signed [ACC_W-1:0] p_acc;
      logic signed [OP_W-1:0]  dx;
      logic signed [OP_W-1:0]  dy;
      if (i == 0) begin : g_first
        assign p_ctl = pctl_r[l];
        assign p_x   = px_r[l];
        assign p_y   = py_r[l];
        assign p_acc = '0;
      end else begin : g_next
        assign p_ctl = cctl_r[i-1][l];
        assign p_x   = cx_r[i-1][l];
        assign p_y   = cy_r[i-1][l];
        assign p_acc = cacc_r[i-1][l];
      end
      assign dx = p_y >>> i;
      assign dy = p_x >>> i;
      always_ff @(posedge clk) begin
        if (adv) begin
          cctl_r[i][l] <= p_ctl;
          if (p_y > 0) begin
            cx_r[i][l]   <= p_x + dx;
            cy_r[i][l]   <= p_y - dy;
            cacc_r[i][l] <= p_acc + atan_entry(5'(i));
          end else begin
            cx_r[i][l]   <= p_x - dx;
            cy_r[i][l]   <= p_y + dy;
            cacc_r[i][l] <= p_acc - atan_entry(5'(i));
          end
        end
      end
    end
  end

  // rounding, quadrant offset, clamp and special-case select
  logic signed [ANG_W-1:0] ang[2];

  for (genvar l = 0; l < 2; l++) begin : g_fin
    localparam int LIMIT = (l == 0) ? HALF_TURN : QUARTER_TURN;
    logic signed [ACC_W-1:0] acc;
    logic        [ACC_W-1:0] mag;
    logic        [ACC_W-1:0] rmag;
    logic signed [ACC_W-1:0] res;
    angle_ctl_t              ctl;
    assign acc  = cacc_r[IT-1][l];
    assign ctl  = cctl_r[IT-1][l];
    assign mag  = (acc < 0) ? ACC_W'(-acc) : ACC_W'(acc);
    assign rmag = (mag + ACC_W'(1 << (FRAC_W-1))) >> FRAC_W;
    always_comb begin
      res = (acc < 0) ? -$signed(rmag) : $signed(rmag);
      res = res + ACC_W'(ctl.base);
      if (res > ACC_W'(LIMIT))  res = ACC_W'(LIMIT);
      if (res < -ACC_W'(LIMIT)) res = -ACC_W'(LIMIT);
      if (ctl.fixed_en) ang[l] = ctl.fixed_val;
      else              ang[l] = res[ANG_W-1:0];
    end
  end

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv_r[IT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {ang[1][14:0], ang[0][15:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TW-OUT_W){1'b0}}, out_data_r};

endmodule

/* sv/atrp_checker.sv */
`timescale 1ns / 1ps
`include "accel_tilt_roll_pitch_macros.svh"
module atrp_checker
  import atrp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_TW-1:0]  in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata
);

  `ATRP_ASSERT_NEXT_ALL(a_reset_clears, !rst_n, !out_tvalid)
  `ATRP_ASSERT_IMPL(a_ready_when_empty, !out_tvalid, in_tready)
  `ATRP_ASSERT_NEXT(a_hold_stalled, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ATRP_ASSERT_IMPL(a_roll_range, out_tvalid, ($signed(out_tdata[15:0]) <= 16'sd18000) && ($signed(out_tdata[15:0]) >= -16'sd18000))
  `ATRP_ASSERT_IMPL(a_pitch_range, out_tvalid, ($signed(out_tdata[30:16]) <= 15'sd9000) && ($signed(out_tdata[30:16]) >= -15'sd9000))

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);

/* sim/tb_accel_tilt_roll_pitch.sv */
`timescale 1ns / 1ps
module tb_accel_tilt_roll_pitch;
  import atrp_pkg::*;

  localparam int LATENCY = 40;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } tilt_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  tilt_t  angle_q[$];
  int     n_sent = 0;
  int     n_got = 0;
  int     n_bad = 0;
  bit     rx_idle = 1'b1;

  accel_tilt_roll_pitch DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan2_cdeg(longint num, longint den, longint lim);
    longint tab[24] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                        5866610, 2933484, 1466764, 733385, 366693, 183346,
                        91673, 45837, 22918, 11459, 5730, 2865,
                        1432, 716, 358, 179, 90, 45};
    longint base, xv, yv, acc, res, dx, dy;
    base = 0;
    acc = 0;
    if (num == 0) return (den < 0) ? HALF_TURN : 0;
    if (den == 0) return (num > 0) ? QUARTER_TURN : -QUARTER_TURN;
    if (den < 0) begin
      base = (num > 0) ? HALF_TURN : -HALF_TURN;
      den = -den;
      num = -num;
    end
    xv = den <<< 24;
    yv = num <<< 24;
    for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
      dx = shr_floor(yv, i);
      dy = shr_floor(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; acc += tab[i];
      end else begin
        xv -= dx; yv += dy; acc -= tab[i];
      end
    end
    if (acc >= 0) res = (acc + 32768) >>> 16;
    else res = -(((-acc) + 32768) >>> 16);
    res += base;
    if (res > lim) res = lim;
    if (res < -lim) res = -lim;
    return res;
  endfunction

  function automatic tilt_t predict_tilt(logic signed [13:0] ax, logic signed [13:0] ay,
                                         logic signed [13:0] az);
    tilt_t t;
    longint x, y, z, r;
    x = ax; y = ay; z = az;
    r = isqrt((y * y + z * z) << 16);
    t.roll = 16'(atan2_cdeg(y, z, HALF_TURN));
    t.pitch = 15'(atan2_cdeg(x * 256, r, QUARTER_TURN));
    return t;
  endfunction

  task automatic send_sample(logic signed [13:0] ax, logic signed [13:0] ay,
                             logic signed [13:0] az, bit gaps);
    int g;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (g > 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    in_tdata <= IN_TW'({az, ay, ax});
    in_tvalid <= 1'b1;
    angle_q.push_back(predict_tilt(ax, ay, az));
    do @(posedge clk); while (!in_tready);
    n_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_idle) out_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    tilt_t exp_t;
    tilt_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = tilt_t'({out_tdata[30:16], out_tdata[15:0]});
      n_got++;
      if (angle_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected item roll=%0d pitch=%0d", got.roll, got.pitch);
      end else begin
        exp_t = angle_q.pop_front();
        if (got.roll !== exp_t.roll || got.pitch !== exp_t.pitch) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected roll=%0d pitch=%0d, got roll=%0d pitch=%0d",
                     exp_t.roll, exp_t.pitch, got.roll, got.pitch);
        end
      end
    end
  end

  task automatic test_directed;
    logic signed [13:0] e[5] = '{-14'sd8192, 14'sd8191, 14'sd0, 14'sd1, -14'sd1};
    send_sample(0, 0, 0, 0);
    send_sample(100, 0, -500, 0);
    send_sample(0, 300, 0, 0);
    send_sample(0, -300, 0, 0);
    send_sample(50, 200, -400, 0);
    send_sample(-50, -200, -400, 0);
    send_sample(14'sd8191, 0, 0, 0);
    send_sample(-14'sd8192, 0, 0, 0);
    for (int i = 0; i < 5; i++)
      send_sample(e[i], e[(i + 1) % 5], e[(i + 3) % 5], 0);
    send_sample(-14'sd8192, -14'sd8192, -14'sd8192, 0);
    send_sample(14'sd8191, 14'sd8191, 14'sd8191, 0);
    send_sample(1, 14'sd8191, 1, 0);
    send_sample(-1, 1, -14'sd8192, 0);
  endtask

  task automatic test_random_back_to_back;
    for (int i = 0; i < 600; i++)
      send_sample(14'($urandom), 14'($urandom), 14'($urandom), 0);
  endtask

  task automatic test_random_with_gaps;
    rx_idle = 1'b0;
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_sample(14'($signed($urandom_range(0, 8)) - 4), 14'($urandom_range(0, 6)) - 14'd3,
                    14'($urandom), 1);
      else
        send_sample(14'($urandom), 14'($urandom), 14'($urandom), 1);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_back_to_back();
    test_random_with_gaps();
    in_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d samples, checked %0d roll/pitch items, %0d mismatches",
             n_sent, n_got, n_bad);
    if (n_bad == 0 && angle_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/atrp_pkg.sv
sv/accel_tilt_roll_pitch.sv
sv/atrp_checker.sv
sim/tb_accel_tilt_roll_pitch.sv
